// ===== design/parallel_port_byte_sender_core_defines.svh =====
// Assertion macros shared by the parallel-port byte sender RTL.
// Standalone header: needs only the clock and reset names passed in.
`ifndef PARALLEL_PORT_BYTE_SENDER_CORE_DEFINES_SVH
`define PARALLEL_PORT_BYTE_SENDER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define PPS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("pps: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted
`define PPS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("pps: next-cycle check failed");

`endif

// ===== design/pps_pkg.sv =====
// Shared types and constants for the parallel-port byte sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package pps_pkg;

    localparam int TICK_W  = 20;
    localparam int RETRY_W = 8;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TICK_W-1:0]  RETRY_INTERVAL_RESET = TICK_W'(100000);
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET    = RETRY_W'(80);

    typedef enum logic [1:0] {
        CMD_DATA     = 2'd0,
        CMD_CTRL     = 2'd1,
        CMD_NEW_FILE = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_RTS_CONFLICT = 2'd1,
        ST_ACK_TIMEOUT  = 2'd2
    } status_t;

    typedef enum logic {
        REG_RETRY_INTERVAL = 1'b0,
        REG_MAX_RETRIES    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0]  retry_interval;
        logic [RETRY_W-1:0] max_retries;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              ack_line;
        logic              remote_rts_line;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              strobe_pulse;
        logic              done_res;
        status_t           status;
        logic              busy_res;
        logic [SUM_W-1:0]  checksum_out;
    } result_t;

endpackage

`default_nettype wire

// ===== design/pps_cfg_regs.sv =====
// APB-style configuration registers: retry interval and retry limit.
// Depends on pps_pkg for the register map and the cfg_t bundle.
`default_nettype none

module pps_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pps_pkg::DATA_W-1:0] pwdata,
    output logic      [pps_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output pps_pkg::cfg_t                   cfg
);
    import pps_pkg::*;

    logic [TICK_W-1:0]  retry_interval_reg;
    logic [RETRY_W-1:0] max_retries_reg;
    reg_idx_t           idx;
    logic               wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_interval_reg <= RETRY_INTERVAL_RESET;
            max_retries_reg    <= MAX_RETRIES_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RETRY_INTERVAL: retry_interval_reg <= pwdata[TICK_W-1:0];
                REG_MAX_RETRIES:    max_retries_reg    <= pwdata[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_RETRY_INTERVAL: prdata = DATA_W'(retry_interval_reg);
            REG_MAX_RETRIES:    prdata = DATA_W'(max_retries_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.retry_interval = retry_interval_reg;
    assign cfg.max_retries    = max_retries_reg;

endmodule

`default_nettype wire

// ===== design/pps_engine.sv =====
// Handshake state and one-step update: latches bytes, watches ACK/RTS,
// retries strobe and keeps the file checksum. Depends on pps_pkg.
`default_nettype none

module pps_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  pps_pkg::item_t       item,
    input  pps_pkg::cfg_t        cfg,
    output pps_pkg::result_t     res
);
    import pps_pkg::*;

    logic               waiting_reg,  waiting_next;
    logic               last_ack_reg, last_ack_next;
    logic               last_rts_reg, last_rts_next;
    logic [TICK_W-1:0]  tick_reg,     tick_next;
    logic [RETRY_W-1:0] retry_reg,    retry_next;
    logic [SUM_W-1:0]   sum_reg,      sum_next;
    logic               odd_reg,      odd_next;
    logic [BYTE_W-1:0]  held_reg,     held_next;
    logic [TICK_W-1:0]  tick_inc;
    logic               strobe;
    logic               done;
    status_t            st;

    assign tick_inc = tick_reg + TICK_W'(1);

    always_comb
    begin
        waiting_next  = waiting_reg;
        last_ack_next = last_ack_reg;
        last_rts_next = last_rts_reg;
        tick_next     = tick_reg;
        retry_next    = retry_reg;
        sum_next      = sum_reg;
        odd_next      = odd_reg;
        held_next     = held_reg;
        strobe        = 1'b0;
        done          = 1'b0;
        st            = ST_OK;

        unique case (item.cmd) inside
            CMD_DATA, CMD_CTRL:
            begin
                // a pending byte is dropped silently; restart the counters
                held_next    = item.data_byte;
                waiting_next = 1'b1;
                tick_next    = '0;
                retry_next   = '0;
                strobe       = 1'b1;
                if (item.cmd == CMD_DATA)
                begin
                    if (odd_reg)
                        sum_next = sum_reg + {{(SUM_W-BYTE_W){1'b0}}, item.data_byte};
                    else
                        sum_next = sum_reg + {item.data_byte, {(SUM_W-BYTE_W){1'b0}}};
                    odd_next = ~odd_reg;
                end
            end
            CMD_NEW_FILE:
            begin
                sum_next      = '0;
                odd_next      = 1'b0;
                last_ack_next = item.ack_line;
                last_rts_next = item.remote_rts_line;
                waiting_next  = 1'b0;
            end
            CMD_TICK:
            begin
                if (waiting_reg)
                begin
                    // ACK edge takes priority over an RTS change
                    if (item.ack_line != last_ack_reg)
                    begin
                        last_ack_next = item.ack_line;
                        waiting_next  = 1'b0;
                        done          = 1'b1;
                    end
                    else if (item.remote_rts_line != last_rts_reg)
                    begin
                        last_rts_next = item.remote_rts_line;
                        waiting_next  = 1'b0;
                        done          = 1'b1;
                        st            = ST_RTS_CONFLICT;
                    end
                    else if (tick_inc == cfg.retry_interval)
                    begin
                        strobe    = 1'b1;
                        tick_next = '0;
                        if (retry_reg >= cfg.max_retries)
                        begin
                            waiting_next = 1'b0;
                            done         = 1'b1;
                            st           = ST_ACK_TIMEOUT;
                        end
                        else
                        begin
                            retry_next = retry_reg + RETRY_W'(1);
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg  <= 1'b0;
            last_ack_reg <= 1'b0;
            last_rts_reg <= 1'b0;
            tick_reg     <= '0;
            retry_reg    <= '0;
            sum_reg      <= '0;
            odd_reg      <= 1'b0;
            held_reg     <= '0;
        end
        else if (fire)
        begin
            waiting_reg  <= waiting_next;
            last_ack_reg <= last_ack_next;
            last_rts_reg <= last_rts_next;
            tick_reg     <= tick_next;
            retry_reg    <= retry_next;
            sum_reg      <= sum_next;
            odd_reg      <= odd_next;
            held_reg     <= held_next;
        end
    end

    assign res.data_out     = held_next;
    assign res.strobe_pulse = strobe;
    assign res.done_res     = done;
    assign res.status       = st;
    assign res.busy_res     = waiting_next;
    assign res.checksum_out = sum_next;

endmodule

`default_nettype wire

// ===== design/parallel_port_byte_sender_core.sv =====
// Top level of the parallel-port byte sender: input register, step engine,
// result register and configuration port. Depends on pps_pkg, pps_cfg_regs,
// pps_engine and the shared assertion header.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  cmd, data_byte, ack_line, remote_rts_line
//   out       output     out_valid / out_stall data_out, strobe_pulse, done_res,
//                                             status, busy_res, checksum_out
//   config    input      APB psel/penable     paddr, pwdata, prdata
//
// Every transaction yields exactly one result transaction, held first in the input
// register and then in the result register. One transaction per cycle is sustained
// while the output is not stalled; the state update is a single pass.
// A stall on the output holds the result and, once the input register is
// also full, raises in_stall. Reset clears all handshake state, configuration
// returns to an interval of 100000 ticks and a limit of 80 retries.
`default_nettype none

`include "parallel_port_byte_sender_core_defines.svh"

module parallel_port_byte_sender_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic [pps_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       ack_line,
    input  wire logic                       remote_rts_line,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [pps_pkg::BYTE_W-1:0]      data_out,
    output logic                            strobe_pulse,
    output logic                            done_res,
    output logic [1:0]                      status,
    output logic                            busy_res,
    output logic [pps_pkg::SUM_W-1:0]       checksum_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pps_pkg::DATA_W-1:0] pwdata,
    output logic [pps_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import pps_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    fire;
    logic    accept;

    pps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the result register can take a new value when empty or being drained
    assign out_free = ~out_valid_reg | ~out_stall;
    assign fire     = item_valid_reg & out_free;
    assign in_stall = item_valid_reg & ~out_free;
    assign accept   = in_valid & ~in_stall;

    assign item_valid_next = accept | (item_valid_reg & ~fire);
    assign out_valid_next  = fire | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd             <= cmd_t'(cmd);
            item_reg.data_byte       <= data_byte;
            item_reg.ack_line        <= ack_line;
            item_reg.remote_rts_line <= remote_rts_line;
        end
        if (fire)
            res_reg <= res;
    end

    pps_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out_valid    = out_valid_reg;
    assign data_out     = res_reg.data_out;
    assign strobe_pulse = res_reg.strobe_pulse;
    assign done_res     = res_reg.done_res;
    assign status       = res_reg.status;
    assign busy_res     = res_reg.busy_res;
    assign checksum_out = res_reg.checksum_out;

    `PPS_ASSERT_SAME(a_status_only_when_done, clk, rst_n,
        out_valid && !done_res, status == ST_OK)
    `PPS_ASSERT_SAME(a_done_ends_wait, clk, rst_n,
        out_valid && done_res, !busy_res)
    `PPS_ASSERT_NEXT(a_send_strobes, clk, rst_n,
        fire && (item_reg.cmd == CMD_DATA || item_reg.cmd == CMD_CTRL),
        out_valid && strobe_pulse && busy_res && !done_res)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for parallel_port_byte_sender_core: directed and random traffic,
// with a scoreboard that predicts every result transaction from the accepted commands.
// Depends on pps_pkg and the RTL of the block.
`default_nettype none

module testbench;
    import pps_pkg::*;

    class sender_scoreboard;
        logic [TICK_W-1:0]  cfg_interval;
        logic [RETRY_W-1:0] cfg_retry_limit;
        logic               awaiting_ack;
        logic               ack_seen;
        logic               rts_seen;
        logic               low_half;
        logic [TICK_W-1:0]  idle_ticks;
        logic [RETRY_W-1:0] strobe_retries;
        logic [SUM_W-1:0]   file_sum;
        logic [BYTE_W-1:0]  latched_byte;
        result_t            lines_due[$];
        int                 fails;

        function new();
            cfg_interval    = RETRY_INTERVAL_RESET;
            cfg_retry_limit = MAX_RETRIES_RESET;
            awaiting_ack    = 1'b0;
            ack_seen        = 1'b0;
            rts_seen        = 1'b0;
            low_half        = 1'b0;
            idle_ticks      = '0;
            strobe_retries  = '0;
            file_sum        = '0;
            latched_byte    = '0;
            fails           = 0;
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            fails++;
        endtask

        function result_t advance_sender(item_t it);
            result_t r;
            r = '0;
            r.status = ST_OK;
            case (it.cmd)
                CMD_DATA, CMD_CTRL:
                begin
                    latched_byte   = it.data_byte;
                    awaiting_ack   = 1'b1;
                    idle_ticks     = '0;
                    strobe_retries = '0;
                    r.strobe_pulse = 1'b1;
                    if (it.cmd == CMD_DATA)
                    begin
                        // even positions fill the high byte, odd ones the low byte
                        if (low_half)
                            file_sum = file_sum + {8'h00, it.data_byte};
                        else
                            file_sum = file_sum + {it.data_byte, 8'h00};
                        low_half = !low_half;
                    end
                end
                CMD_NEW_FILE:
                begin
                    file_sum     = '0;
                    low_half     = 1'b0;
                    ack_seen     = it.ack_line;
                    rts_seen     = it.remote_rts_line;
                    awaiting_ack = 1'b0;
                end
                default:
                begin
                    if (awaiting_ack)
                    begin
                        if (it.ack_line != ack_seen)
                        begin
                            ack_seen     = it.ack_line;
                            awaiting_ack = 1'b0;
                            r.done_res   = 1'b1;
                        end
                        else if (it.remote_rts_line != rts_seen)
                        begin
                            rts_seen     = it.remote_rts_line;
                            awaiting_ack = 1'b0;
                            r.done_res   = 1'b1;
                            r.status     = ST_RTS_CONFLICT;
                        end
                        else
                        begin
                            // 20-bit wrap makes an interval of zero mean 2^20 ticks
                            idle_ticks = idle_ticks + 1'b1;
                            if (idle_ticks == cfg_interval)
                            begin
                                r.strobe_pulse = 1'b1;
                                idle_ticks     = '0;
                                if (strobe_retries >= cfg_retry_limit)
                                begin
                                    awaiting_ack = 1'b0;
                                    r.done_res   = 1'b1;
                                    r.status     = ST_ACK_TIMEOUT;
                                end
                                else
                                    strobe_retries = strobe_retries + 1'b1;
                            end
                        end
                    end
                end
            endcase
            r.data_out     = latched_byte;
            r.busy_res     = awaiting_ack;
            r.checksum_out = file_sum;
            return r;
        endfunction

        function void note_command(item_t it);
            lines_due.push_back(advance_sender(it));
        endfunction

        task check_lines(result_t got);
            result_t want;
            if (lines_due.size() == 0)
            begin
                report("result transaction with nothing outstanding");
                return;
            end
            want = lines_due.pop_front();
            if (got.data_out !== want.data_out)
                report($sformatf("data_out %h, expected %h", got.data_out, want.data_out));
            if (got.strobe_pulse !== want.strobe_pulse)
                report($sformatf("strobe_pulse %b, expected %b",
                                 got.strobe_pulse, want.strobe_pulse));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
            if (got.checksum_out !== want.checksum_out)
                report($sformatf("checksum_out %h, expected %h",
                                 got.checksum_out, want.checksum_out));
        endtask

        function int pending();
            return lines_due.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          cmd = CMD_TICK;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                ack_line = 1'b0;
    logic                remote_rts_line = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [BYTE_W-1:0]   data_out;
    logic                strobe_pulse;
    logic                done_res;
    logic [1:0]          status;
    logic                busy_res;
    logic [SUM_W-1:0]    checksum_out;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sender_scoreboard    sb;
    result_t             seen_lines;
    int                  items_sent = 0;
    int                  in_idle_pct = 15;
    int                  out_idle_pct = 52;

    int unsigned phase_interval[6] = '{1, 3, 2, 1048575, 0, 4};
    int unsigned phase_retries[6]  = '{0, 2, 255, 255, 1, 1};

    parallel_port_byte_sender_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .data_byte       (data_byte),
        .ack_line        (ack_line),
        .remote_rts_line (remote_rts_line),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_out        (data_out),
        .strobe_pulse    (strobe_pulse),
        .done_res        (done_res),
        .status          (status),
        .busy_res        (busy_res),
        .checksum_out    (checksum_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_lines.data_out     = data_out;
            seen_lines.strobe_pulse = strobe_pulse;
            seen_lines.done_res     = done_res;
            seen_lines.status       = status_t'(status);
            seen_lines.busy_res     = busy_res;
            seen_lines.checksum_out = checksum_out;
            sb.check_lines(seen_lines);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic push_command(cmd_t c, logic [BYTE_W-1:0] b, logic a, logic r);
        item_t it;
        it.cmd             = c;
        it.data_byte       = b;
        it.ack_line        = a;
        it.remote_rts_line = r;
        items_sent++;
        in_idle_pct  = (items_sent < 225) ? 15 : (items_sent < 450) ? 52 : 0;
        out_idle_pct = (items_sent < 225) ? 52 : (items_sent < 450) ? 15 : 0;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= c;
        data_byte       <= b;
        ack_line        <= a;
        remote_rts_line <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_command(it);
        @(negedge clk);
    endtask

    // Tick with both lines held at their last sampled levels.
    task automatic hold_tick();
        push_command(CMD_TICK, BYTE_W'($urandom_range(255)), sb.ack_seen, sb.rts_seen);
    endtask

    // Leaves psel high; the caller closes the burst.
    task automatic apb_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain all outstanding results before touching the registers.
    task automatic set_timing(logic [TICK_W-1:0] interval, logic [RETRY_W-1:0] limit);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        apb_write({REG_RETRY_INTERVAL, 2'b00}, DATA_W'(interval));
        apb_write({REG_MAX_RETRIES, 2'b00}, DATA_W'(limit));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.cfg_interval    = interval;
        sb.cfg_retry_limit = limit;
    endtask

    task automatic run_traffic(int target);
        int n_ticks;
        int ending;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 72)
            begin
                // send, hold the lines a while, then usually let the receiver answer
                if ($urandom_range(9) == 0)
                    push_command(CMD_NEW_FILE, BYTE_W'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                push_command(($urandom_range(4) == 0) ? CMD_CTRL : CMD_DATA,
                             BYTE_W'($urandom_range(255)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                n_ticks = $urandom_range(12);
                repeat (n_ticks) hold_tick();
                ending = $urandom_range(3);
                if (ending < 3)
                    push_command(CMD_TICK, BYTE_W'($urandom_range(255)),
                                 sb.ack_seen ^ (ending != 1), sb.rts_seen ^ (ending != 0));
            end
            else
                push_command(cmd_t'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        hold_tick();
        push_command(CMD_NEW_FILE, 8'h00, 1'b1, 1'b1);
        // checksum wraps back to zero on the fourth byte
        push_command(CMD_DATA, 8'h00, 1'b1, 1'b1);
        push_command(CMD_DATA, 8'hFF, 1'b1, 1'b1);
        push_command(CMD_DATA, 8'hFF, 1'b0, 1'b0);
        push_command(CMD_DATA, 8'h01, 1'b0, 1'b1);
        push_command(CMD_CTRL, 8'h80, 1'b1, 1'b0);
        hold_tick();
        push_command(CMD_TICK, 8'h00, !sb.ack_seen, sb.rts_seen);
        push_command(CMD_CTRL, 8'h7F, 1'b0, 1'b0);
        push_command(CMD_TICK, 8'hFF, sb.ack_seen, !sb.rts_seen);
        push_command(CMD_DATA, 8'h33, 1'b1, 1'b1);
        push_command(CMD_TICK, 8'h00, !sb.ack_seen, !sb.rts_seen);
        push_command(CMD_DATA, 8'h44, 1'b0, 1'b1);
        push_command(CMD_CTRL, 8'h55, 1'b1, 1'b0);
        hold_tick();
        push_command(CMD_NEW_FILE, 8'hAA, 1'b0, 1'b0);
        push_command(CMD_TICK, 8'h55, 1'b1, 1'b1);

        set_timing(TICK_W'(1), RETRY_W'(0));
        push_command(CMD_DATA, 8'hA5, 1'b0, 1'b0);
        hold_tick();
        set_timing(TICK_W'(2), RETRY_W'(1));
        push_command(CMD_CTRL, 8'h5A, 1'b1, 1'b1);
        repeat (4) hold_tick();

        foreach (phase_interval[i])
        begin
            set_timing(TICK_W'(phase_interval[i]), RETRY_W'(phase_retries[i]));
            run_traffic(items_sent + 105);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("parallel_port_byte_sender_core: match");
        else
            $display("parallel_port_byte_sender_core: mismatch");
        $finish;
    end

    initial
    begin
        #(8 * 200000);
        $display("parallel_port_byte_sender_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
